### sv/imv_pkg.sv
package imv_pkg;

   localparam int LEN_WIDTH = 16;
   localparam logic [LEN_WIDTH-1:0] MAX_MSG_BYTES = 16'hFFFF;
   localparam logic [LEN_WIDTH-1:0] ECHO_HDR_LEN = 16'd8;
   localparam logic [15:0] SUM_GOOD = 16'hFFFF;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_HEADER_LEN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ECHO_PAYLOAD = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNREACH_MAX_CODE = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_EXCEEDED_MAX_CODE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REDIRECT_MIN_CODE = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REDIRECT_MAX_CODE = 3'd5;

   localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
   localparam logic [7:0] TYPE_UNREACH = 8'd3;
   localparam logic [7:0] TYPE_QUENCH = 8'd4;
   localparam logic [7:0] TYPE_REDIRECT = 8'd5;
   localparam logic [7:0] TYPE_ECHO_REQ = 8'd8;
   localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
   localparam logic [7:0] TYPE_PARAM_PROBLEM = 8'd12;
   localparam logic [7:0] TYPE_TS = 8'd13;
   localparam logic [7:0] TYPE_TS_REPLY = 8'd14;
   localparam logic [7:0] TYPE_INFO_REQ = 8'd15;
   localparam logic [7:0] TYPE_INFO_REPLY = 8'd16;
   localparam logic [7:0] TYPE_MASK_REQ = 8'd17;
   localparam logic [7:0] TYPE_MASK_REPLY = 8'd18;

   typedef enum logic [3:0] {
      ST_OK             = 4'd0,
      ST_SHORT          = 4'd1,
      ST_BAD_TYPE       = 4'd2,
      ST_ECHO_SHORT     = 4'd3,
      ST_ECHO_CODE      = 4'd4,
      ST_REPLY_SHORT    = 4'd5,
      ST_REPLY_CODE     = 4'd6,
      ST_COVERT         = 4'd7,
      ST_UNREACH_CODE   = 4'd8,
      ST_TIME_CODE      = 4'd9,
      ST_REDIRECT_CODE  = 4'd10,
      ST_TS_CODE        = 4'd11,
      ST_INFO_CODE      = 4'd12,
      ST_CHECKSUM       = 4'd13
   } status_type;

   typedef struct packed {
      logic [7:0]  min_header_len;
      logic [15:0] max_echo_payload;
      logic [7:0]  unreach_max_code;
      logic [7:0]  time_exceeded_max_code;
      logic [7:0]  redirect_min_code;
      logic [7:0]  redirect_max_code;
   } cfg_type;

endpackage

### sv/icmp_message_validator_core.sv
// ICMP message validator.
// Request channel (req_valid / req_stall): one message byte per request, header
// first, with req_last_byte set on the final byte. Result channel (rsp_valid /
// rsp_stall): one verdict per message, carrying status, type byte and code byte.
// Configuration: csr_write with csr_index and csr_wdata sets the limits; indexes
// past the register list are ignored. Write only while no message is in flight.
// A last byte goes through the input register, then the message state and result
// register, before its result shows on rsp_valid.
// Throughput: one byte per cycle while req_stall is low, set by the single pass
// through the 16-bit end-around-carry adder and the verdict compares.
// Reset (synchronous, active high) empties both registers, clears the message
// state and loads the default limits.
// When rsp_stall holds a waiting result, bytes that are not the last keep
// flowing; a last byte waits in the input register, and the request side then
// stalls until the waiting result is taken.
module icmp_message_validator_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [3:0]                           rsp_status,
   output logic [7:0]                           rsp_message_type,
   output logic [7:0]                           rsp_message_code,
   input  logic                                 csr_write,
   input  logic [imv_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [imv_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   imv_pkg::cfg_type cfg_ff;

   logic        s1_valid_ff;
   logic        s1_last_ff;
   logic [7:0]  s1_data_ff;

   logic [imv_pkg::LEN_WIDTH-1:0] cnt_ff;
   logic [7:0]  type_ff;
   logic [7:0]  code_ff;
   logic [15:0] sum_ff;
   logic [7:0]  held_ff;
   logic        pend_ff;

   logic        rsp_valid_ff;
   logic [3:0]  rsp_status_ff;
   logic [7:0]  rsp_type_ff;
   logic [7:0]  rsp_code_ff;

   logic        proc_ready;
   logic        proc_fire;
   logic [15:0] word_in;
   logic [15:0] sum_in;
   logic [imv_pkg::LEN_WIDTH-1:0] cnt_in;
   logic [7:0]  type_in;
   logic [7:0]  code_in;
   imv_pkg::status_type status_in;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_header_len <= 8'd8;
         cfg_ff.max_echo_payload <= 16'd48;
         cfg_ff.unreach_max_code <= 8'd5;
         cfg_ff.time_exceeded_max_code <= 8'd1;
         cfg_ff.redirect_min_code <= 8'd0;
         cfg_ff.redirect_max_code <= 8'd3;
      end else if (csr_write) begin
         unique case (csr_index)
            imv_pkg::CSR_MIN_HEADER_LEN: cfg_ff.min_header_len <= csr_wdata[7:0];
            imv_pkg::CSR_MAX_ECHO_PAYLOAD: cfg_ff.max_echo_payload <= csr_wdata;
            imv_pkg::CSR_UNREACH_MAX_CODE: cfg_ff.unreach_max_code <= csr_wdata[7:0];
            imv_pkg::CSR_TIME_EXCEEDED_MAX_CODE: begin
               cfg_ff.time_exceeded_max_code <= csr_wdata[7:0];
            end
            imv_pkg::CSR_REDIRECT_MIN_CODE: cfg_ff.redirect_min_code <= csr_wdata[7:0];
            imv_pkg::CSR_REDIRECT_MAX_CODE: cfg_ff.redirect_max_code <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // a last byte may only advance when the result register is free or draining
   assign proc_ready = !s1_last_ff || !rsp_valid_ff || !rsp_stall;
   assign proc_fire  = s1_valid_ff && proc_ready;
   assign req_stall  = s1_valid_ff && !proc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // an odd trailing byte pairs with zero, so the word is the same either way
   assign word_in = pend_ff ? {held_ff, s1_data_ff} : {s1_data_ff, 8'h00};
   assign sum_in  = oc_add(sum_ff, word_in);
   assign cnt_in  = (cnt_ff != imv_pkg::MAX_MSG_BYTES) ?
                    cnt_ff + imv_pkg::LEN_WIDTH'(1) : cnt_ff;
   assign type_in = (cnt_ff == '0) ? s1_data_ff : type_ff;
   assign code_in = (cnt_ff == imv_pkg::LEN_WIDTH'(1)) ? s1_data_ff : code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         type_ff <= 8'd0;
         code_ff <= 8'd0;
         sum_ff  <= 16'd0;
         held_ff <= 8'd0;
         pend_ff <= 1'b0;
      end else if (proc_fire) begin
         if (s1_last_ff) begin
            cnt_ff  <= '0;
            type_ff <= 8'd0;
            code_ff <= 8'd0;
            sum_ff  <= 16'd0;
            held_ff <= 8'd0;
            pend_ff <= 1'b0;
         end else begin
            cnt_ff  <= cnt_in;
            type_ff <= type_in;
            code_ff <= code_in;
            if (pend_ff) begin
               sum_ff <= sum_in;
            end else begin
               held_ff <= s1_data_ff;
            end
            pend_ff <= !pend_ff;
         end
      end
   end

   imv_verdict u_verdict (
      .cfg      (cfg_ff),
      .msg_len  (cnt_in),
      .msg_type (type_in),
      .msg_code (code_in),
      .msg_sum  (sum_in),
      .status   (status_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (proc_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && s1_last_ff) begin
         rsp_status_ff <= status_in;
         rsp_type_ff   <= type_in;
         rsp_code_ff   <= code_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_message_type = rsp_type_ff;
   assign rsp_message_code = rsp_code_ff;

`ifndef SYNTHESIS
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(proc_fire && s1_last_ff))
      else $error("result raised without a last byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      proc_fire && s1_last_ff |=> cnt_ff == '0 && !pend_ff && sum_ff == 16'd0)
      else $error("message state not cleared after last byte");

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s1_last_ff && rsp_valid_ff)
      else $error("request stalled without a waiting last byte");

   a_ok_means_sum: assert property (@(posedge clock) disable iff (reset)
      proc_fire && s1_last_ff && status_in == imv_pkg::ST_OK |-> sum_in == imv_pkg::SUM_GOOD)
      else $error("ok verdict with bad checksum");
`endif

endmodule

### sv/imv_verdict.sv
module imv_verdict (
   input  imv_pkg::cfg_type                   cfg,
   input  logic [imv_pkg::LEN_WIDTH-1:0]      msg_len,
   input  logic [7:0]                         msg_type,
   input  logic [7:0]                         msg_code,
   input  logic [15:0]                        msg_sum,
   output imv_pkg::status_type                status
);

   logic                              is_echo_req;
   logic [imv_pkg::LEN_WIDTH-1:0]     payload_len;
   logic                              code_nonzero;

   assign is_echo_req  = (msg_type == imv_pkg::TYPE_ECHO_REQ);
   assign payload_len  = msg_len - imv_pkg::ECHO_HDR_LEN;
   assign code_nonzero = (msg_code != 8'd0);

   always_comb begin
      logic       failed;
      logic [3:0] hit;
      failed = 1'b1;
      hit    = imv_pkg::ST_OK;
      if (msg_len <= {8'd0, cfg.min_header_len}) begin
         hit = imv_pkg::ST_SHORT;
      end else begin
         failed = 1'b0;
         unique case (msg_type) inside
            imv_pkg::TYPE_ECHO_REQ, imv_pkg::TYPE_ECHO_REPLY: begin
               if (msg_len < imv_pkg::ECHO_HDR_LEN) begin
                  failed = 1'b1;
                  hit = is_echo_req ? imv_pkg::ST_ECHO_SHORT : imv_pkg::ST_REPLY_SHORT;
               end else if (code_nonzero) begin
                  failed = 1'b1;
                  hit = is_echo_req ? imv_pkg::ST_ECHO_CODE : imv_pkg::ST_REPLY_CODE;
               end else if (payload_len > cfg.max_echo_payload) begin
                  failed = 1'b1;
                  hit = imv_pkg::ST_COVERT;
               end
            end
            imv_pkg::TYPE_UNREACH: begin
               if (msg_code > cfg.unreach_max_code) begin
                  failed = 1'b1;
                  hit = imv_pkg::ST_UNREACH_CODE;
               end
            end
            imv_pkg::TYPE_TIME_EXCEEDED: begin
               if (msg_code > cfg.time_exceeded_max_code) begin
                  failed = 1'b1;
                  hit = imv_pkg::ST_TIME_CODE;
               end
            end
            imv_pkg::TYPE_REDIRECT: begin
               if (msg_code < cfg.redirect_min_code || msg_code > cfg.redirect_max_code) begin
                  failed = 1'b1;
                  hit = imv_pkg::ST_REDIRECT_CODE;
               end
            end
            imv_pkg::TYPE_TS, imv_pkg::TYPE_TS_REPLY: begin
               if (code_nonzero) begin
                  failed = 1'b1;
                  hit = imv_pkg::ST_TS_CODE;
               end
            end
            imv_pkg::TYPE_INFO_REQ, imv_pkg::TYPE_INFO_REPLY: begin
               if (code_nonzero) begin
                  failed = 1'b1;
                  hit = imv_pkg::ST_INFO_CODE;
               end
            end
            imv_pkg::TYPE_QUENCH, imv_pkg::TYPE_PARAM_PROBLEM,
            imv_pkg::TYPE_MASK_REQ, imv_pkg::TYPE_MASK_REPLY: begin
               failed = 1'b0;
            end
            default: begin
               failed = 1'b1;
               hit = imv_pkg::ST_BAD_TYPE;
            end
         endcase
      end
      // checksum is judged only when every header check passed
      if (!failed && msg_sum != imv_pkg::SUM_GOOD) begin
         hit = imv_pkg::ST_CHECKSUM;
      end
      status = imv_pkg::status_type'(hit);
   end

endmodule

### bench/icmp_message_validator_core_tb.sv
module icmp_message_validator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [imv_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [imv_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_HI = 3'd7;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 4;

   typedef struct packed {
      imv_pkg::status_type status;
      logic [7:0] msg_type;
      logic [7:0] msg_code;
   } icmp_verdict_type;

   typedef struct packed {
      logic [7:0]       data;
      logic             last;
      logic             typed;
      icmp_verdict_type want;
   } stim_row_type;

   localparam icmp_verdict_type NO_VERDICT = '{imv_pkg::ST_OK, 8'h00, 8'h00};

   // one-byte message, good echo request, all-zero message, unknown type
   localparam stim_row_type DIRECTED_ROWS [28] = '{
      '{8'hFF, 1'b1, 1'b1, '{imv_pkg::ST_SHORT, 8'hFF, 8'h00}},
      '{8'h08, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'hF7, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b1, 1'b1, '{imv_pkg::ST_OK, 8'h08, 8'h00}},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b1, 1'b1, '{imv_pkg::ST_CHECKSUM, 8'h00, 8'h00}},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b1, 1'b1, '{imv_pkg::ST_BAD_TYPE, 8'hFF, 8'hFF}}
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [7:0]                          req_data_byte = 8'h00;
   logic                                req_last_byte = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [3:0]                          rsp_status;
   logic [7:0]                          rsp_message_type;
   logic [7:0]                          rsp_message_code;
   logic                                csr_write = 1'b0;
   logic [imv_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [imv_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // predictor state
   imv_pkg::cfg_type lim = '{8'd8, 16'd48, 8'd5, 8'd1, 8'd0, 8'd3};
   logic [15:0]   seen_len = '0;
   logic [7:0]    seen_type = '0;
   logic [7:0]    seen_code = '0;
   logic [15:0]   word_sum = '0;
   logic [7:0]    held_hi = '0;
   logic          hi_pending = 1'b0;

   icmp_verdict_type verdict_q [$];
   logic [7:0]    msg_buf [$];
   int            fail_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   bit            hold_req = 1'b0;
   int            hold_left = 0;

   icmp_message_validator_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_message_type (rsp_message_type),
      .rsp_message_code (rsp_message_code),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic imv_pkg::status_type judge(input logic [15:0] len,
                                                 input logic [15:0] total);
      if (len <= {8'h00, lim.min_header_len}) return imv_pkg::ST_SHORT;
      case (seen_type)
         imv_pkg::TYPE_ECHO_REQ, imv_pkg::TYPE_ECHO_REPLY: begin
            if (len < imv_pkg::ECHO_HDR_LEN) begin
               if (seen_type == imv_pkg::TYPE_ECHO_REQ) return imv_pkg::ST_ECHO_SHORT;
               return imv_pkg::ST_REPLY_SHORT;
            end
            if (seen_code != 8'h00) begin
               if (seen_type == imv_pkg::TYPE_ECHO_REQ) return imv_pkg::ST_ECHO_CODE;
               return imv_pkg::ST_REPLY_CODE;
            end
            if (len - imv_pkg::ECHO_HDR_LEN > lim.max_echo_payload)
               return imv_pkg::ST_COVERT;
         end
         imv_pkg::TYPE_UNREACH: begin
            if (seen_code > lim.unreach_max_code) return imv_pkg::ST_UNREACH_CODE;
         end
         imv_pkg::TYPE_TIME_EXCEEDED: begin
            if (seen_code > lim.time_exceeded_max_code) return imv_pkg::ST_TIME_CODE;
         end
         imv_pkg::TYPE_REDIRECT: begin
            if (seen_code < lim.redirect_min_code || seen_code > lim.redirect_max_code)
               return imv_pkg::ST_REDIRECT_CODE;
         end
         imv_pkg::TYPE_TS, imv_pkg::TYPE_TS_REPLY: begin
            if (seen_code != 8'h00) return imv_pkg::ST_TS_CODE;
         end
         imv_pkg::TYPE_INFO_REQ, imv_pkg::TYPE_INFO_REPLY: begin
            if (seen_code != 8'h00) return imv_pkg::ST_INFO_CODE;
         end
         imv_pkg::TYPE_QUENCH, imv_pkg::TYPE_PARAM_PROBLEM,
         imv_pkg::TYPE_MASK_REQ, imv_pkg::TYPE_MASK_REPLY: begin
         end
         default: return imv_pkg::ST_BAD_TYPE;
      endcase
      if (total != imv_pkg::SUM_GOOD) return imv_pkg::ST_CHECKSUM;
      return imv_pkg::ST_OK;
   endfunction

   // Advance the message state by one byte; returns 1 when the byte closes a message.
   function automatic bit absorb_byte(input logic [7:0] d, input logic last,
                                      output icmp_verdict_type v);
      logic [15:0] total;
      v = NO_VERDICT;
      if (seen_len == 16'd0) seen_type = d;
      else if (seen_len == 16'd1) seen_code = d;
      if (hi_pending) begin
         word_sum = ones_add(word_sum, {held_hi, d});
         hi_pending = 1'b0;
      end else begin
         held_hi = d;
         hi_pending = 1'b1;
      end
      if (seen_len != imv_pkg::MAX_MSG_BYTES) seen_len = seen_len + 16'd1;
      if (!last) return 1'b0;
      // pad an odd trailing byte with zero
      total = hi_pending ? ones_add(word_sum, {held_hi, 8'h00}) : word_sum;
      v.status = judge(seen_len, total);
      v.msg_type = seen_type;
      v.msg_code = seen_code;
      seen_len = '0;
      seen_type = '0;
      seen_code = '0;
      word_sum = '0;
      held_hi = '0;
      hi_pending = 1'b0;
      return 1'b1;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_byte(input logic [7:0] d, input logic last, input bit typed,
                            input icmp_verdict_type typed_v);
      icmp_verdict_type v;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      if (absorb_byte(d, last, v)) verdict_q.push_back(typed ? typed_v : v);
      @(negedge clock);
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_buf.size(); i++)
         send_byte(msg_buf[i], i == msg_buf.size() - 1, 1'b0, NO_VERDICT);
   endtask

   // Fill the checksum field so the whole message sums to all ones.
   task automatic seal_checksum();
      logic [15:0] s;
      s = '0;
      msg_buf[2] = 8'h00;
      msg_buf[3] = 8'h00;
      for (int i = 0; i < msg_buf.size(); i += 2)
         s = ones_add(s, {msg_buf[i], (i + 1 < msg_buf.size()) ? msg_buf[i + 1] : 8'h00});
      msg_buf[2] = ~s[15:8];
      msg_buf[3] = ~s[7:0];
   endtask

   function automatic logic [7:0] pick_known_type();
      case ($urandom_range(12))
         0:  return imv_pkg::TYPE_ECHO_REPLY;
         1:  return imv_pkg::TYPE_UNREACH;
         2:  return imv_pkg::TYPE_QUENCH;
         3:  return imv_pkg::TYPE_REDIRECT;
         4:  return imv_pkg::TYPE_ECHO_REQ;
         5:  return imv_pkg::TYPE_TIME_EXCEEDED;
         6:  return imv_pkg::TYPE_PARAM_PROBLEM;
         7:  return imv_pkg::TYPE_TS;
         8:  return imv_pkg::TYPE_TS_REPLY;
         9:  return imv_pkg::TYPE_INFO_REQ;
         10: return imv_pkg::TYPE_INFO_REPLY;
         11: return imv_pkg::TYPE_MASK_REQ;
         default: return imv_pkg::TYPE_MASK_REPLY;
      endcase
   endfunction

   task automatic build_random_message();
      int         len;
      int         r;
      logic [7:0] ty;
      logic [7:0] co;
      msg_buf.delete();
      // noise: short runs of arbitrary bytes
      if ($urandom_range(99) < 12) begin
         len = $urandom_range(6, 1);
         repeat (len) msg_buf.push_back(8'($urandom_range(255)));
         return;
      end
      ty = ($urandom_range(99) < 80) ? pick_known_type() : 8'($urandom_range(255));
      if (ty == imv_pkg::TYPE_ECHO_REQ || ty == imv_pkg::TYPE_ECHO_REPLY) begin
         co = ($urandom_range(99) < 70) ? 8'h00 : 8'($urandom_range(255));
      end else begin
         r = $urandom_range(99);
         if (r < 50) co = 8'($urandom_range(7));
         else if (r < 75) begin
            // hit the code limits and one past them
            case ($urandom_range(3))
               0: co = lim.unreach_max_code + 8'($urandom_range(1));
               1: co = lim.time_exceeded_max_code + 8'($urandom_range(1));
               2: co = lim.redirect_min_code - 8'($urandom_range(1));
               default: co = lim.redirect_max_code + 8'($urandom_range(1));
            endcase
         end else co = 8'($urandom_range(255));
      end
      r = $urandom_range(99);
      if (r < 50) len = int'(lim.min_header_len) + $urandom_range(16, 1);
      else if (r < 70) len = $urandom_range(12, 1);
      else if (r < 85) len = int'(lim.min_header_len) + $urandom_range(1);
      else if (r < 95 && lim.max_echo_payload <= 16'd300)
         len = 7 + int'(lim.max_echo_payload) + $urandom_range(2);
      else len = $urandom_range(300, 100);
      if (len < 1) len = 1;
      repeat (len) msg_buf.push_back(8'($urandom_range(255)));
      msg_buf[0] = ty;
      if (len > 1) msg_buf[1] = co;
      if (len >= 4 && $urandom_range(99) < 75) seal_checksum();
   endtask

   task automatic run_messages(input int budget);
      int sent;
      sent = 0;
      while (sent < budget) begin
         build_random_message();
         sent += msg_buf.size();
         send_message();
      end
   endtask

   task automatic write_reg(input logic [imv_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         imv_pkg::CSR_MIN_HEADER_LEN:         lim.min_header_len = data[7:0];
         imv_pkg::CSR_MAX_ECHO_PAYLOAD:       lim.max_echo_payload = data;
         imv_pkg::CSR_UNREACH_MAX_CODE:       lim.unreach_max_code = data[7:0];
         imv_pkg::CSR_TIME_EXCEEDED_MAX_CODE: lim.time_exceeded_max_code = data[7:0];
         imv_pkg::CSR_REDIRECT_MIN_CODE:      lim.redirect_min_code = data[7:0];
         imv_pkg::CSR_REDIRECT_MAX_CODE:      lim.redirect_max_code = data[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Wait for every pending verdict, then let the pipeline go quiet.
   task automatic settle();
      int waited;
      waited = 0;
      while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (verdict_q.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected verdicts never came out", $time, verdict_q.size());
         verdict_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic start_phase(input imv_pkg::cfg_type c, input int send_pct,
                              input int recv_pct, input bit hold);
      req_valid <= 1'b0;
      settle();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      hold_req = hold;
      @(negedge clock);
      // upper byte of the 8-bit registers is junk and must be dropped
      write_reg(imv_pkg::CSR_MIN_HEADER_LEN,
                {8'($urandom_range(255)), c.min_header_len});
      write_reg(imv_pkg::CSR_MAX_ECHO_PAYLOAD, c.max_echo_payload);
      write_reg(imv_pkg::CSR_UNREACH_MAX_CODE,
                {8'($urandom_range(255)), c.unreach_max_code});
      write_reg(imv_pkg::CSR_TIME_EXCEEDED_MAX_CODE,
                {8'($urandom_range(255)), c.time_exceeded_max_code});
      write_reg(imv_pkg::CSR_REDIRECT_MIN_CODE,
                {8'($urandom_range(255)), c.redirect_min_code});
      write_reg(imv_pkg::CSR_REDIRECT_MAX_CODE,
                {8'($urandom_range(255)), c.redirect_max_code});
      write_reg(($urandom_range(1) != 0) ? CSR_SPARE_HI : CSR_SPARE_LO,
                16'($urandom_range(65535)));
      csr_write <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_verdicts
      icmp_verdict_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            fail_count++;
            $display("%0t: verdict with none expected: status %0d type %0d code %0d",
                     $time, rsp_status, rsp_message_type, rsp_message_code);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_status !== want.status) begin
               fail_count++;
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
            end
            if (rsp_message_type !== want.msg_type) begin
               fail_count++;
               $display("%0t: message_type expected %0d got %0d",
                        $time, want.msg_type, rsp_message_type);
            end
            if (rsp_message_code !== want.msg_code) begin
               fail_count++;
               $display("%0t: message_code expected %0d got %0d",
                        $time, want.msg_code, rsp_message_code);
            end
         end
      end
   end

   initial begin : stimulus
      imv_pkg::cfg_type mix_cfg;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 28; i++)
         send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].want);

      // widest limits; hold the result side so the request side backs up
      start_phase('{8'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'h00, 8'hFF}, 0, 0, 1'b1);
      run_messages(230);

      start_phase('{8'd8, 16'd48, 8'd5, 8'd1, 8'd0, 8'd3}, 46, 0, 1'b0);
      run_messages(230);

      // tightest limits: every redirect code fails
      start_phase('{8'd4, 16'd0, 8'd0, 8'd0, 8'hFF, 8'h00}, 0, 46, 1'b0);
      run_messages(230);

      mix_cfg.min_header_len = 8'($urandom_range(10));
      mix_cfg.max_echo_payload = 16'($urandom_range(24));
      mix_cfg.unreach_max_code = 8'($urandom_range(8));
      mix_cfg.time_exceeded_max_code = 8'($urandom_range(4));
      mix_cfg.redirect_min_code = 8'($urandom_range(3));
      mix_cfg.redirect_max_code = 8'($urandom_range(8, 2));
      start_phase(mix_cfg, 21, 21, 1'b0);
      run_messages(170);

      start_phase('{8'hFF, 16'd250, 8'd2, 8'd3, 8'd1, 8'd2}, 21, 21, 1'b0);
      run_messages(110);

      req_valid <= 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin : watchdog
      #(20_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
